// ===== sv/assert_macros.svh =====
// Assertion macros shared by the alert queue RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define RLAQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same-cycle implication check.
`define RLAQ_ASSERT_IMP(label, ante, cons, msg) \
	`RLAQ_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== sv/rlaq_pkg.sv =====
// Types, codes and constants of the rate-limited alert queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package rlaq_pkg;

	// Operation codes carried on s_tuser.
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ROUND_MS     = 2'd0;
	localparam logic [1:0] REG_MAX_PER_TYPE = 2'd1;
	localparam logic [1:0] REG_MAX_QUEUE    = 2'd2;
	localparam logic [1:0] REG_MAX_FPS      = 2'd3;

	// Register reset values.
	localparam logic [15:0] ROUND_MS_RST     = 16'd1000;
	localparam logic [7:0]  MAX_PER_TYPE_RST = 8'd3;
	localparam logic [3:0]  MAX_QUEUE_RST    = 4'd4;

	// Frame interval arithmetic: 1000 / fps, a 10-bit quotient.
	localparam int          INT_W         = 10;
	localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
	localparam logic [9:0]  FRAME_INT_RST = 10'd33;
	localparam logic [3:0]  DIV_STEPS     = 4'd10;

	// One queued alert.
	typedef struct packed {
		logic [3:0]  atype;
		logic [15:0] dur;
		logic [15:0] tag;
	} alert_t;

	// Status of the frame interval divider.
	typedef struct packed {
		logic             busy;
		logic [INT_W-1:0] interval;
	} fdiv_stat_t;

	// Control from the top level to the per-type counter cells.
	typedef struct packed {
		logic upd;
		logic restart;
		logic bump;
	} tcell_ctl_t;

	// One result beat.
	typedef struct packed {
		logic        accepted;
		logic        dropped;
		logic        taken;
		logic        showing;
		logic        started;
		logic [3:0]  cur_type;
		logic [15:0] cur_tag;
		logic [3:0]  qcount;
	} res_t;

	// Set of 4-bit alert types that fold onto counter k when folded modulo tc.
	function automatic logic [15:0] type_match(int k, int tc);
		int          r;
		logic [15:0] m;
		r = 0;
		m = '0;
		for (int v = 0; v < 16; v++) begin
			m[v] = (r == k);
			r = (r == tc - 1) ? 0 : r + 1;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rate_limited_alert_queue.sv =====
// Rate-limited alert queue, top level.
// Depends on rlaq_pkg, rlaq_slot, rlaq_tcell, rlaq_fdiv and assert_macros.svh.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  s_tuser op, s_tdata alert and time
//   m_*       out        m_tvalid/m_tready  m_tdata result flags and status
//   cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each input beat is decoded combinationally; its result sits in an output
// register, so a beat can be taken every cycle while m_tready is high and
// the divider is not busy. A max_fps write runs the interval divider, during
// which s_tready and cfg_ready are low. Reset clears the queue, the per-type
// counters and the display state; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module rate_limited_alert_queue #(
	parameter int unsigned QUEUE_DEPTH = 8,
	parameter int unsigned TYPE_COUNT  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input beats.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [31:0] now_ms, [35:32] alert_type, [51:36] alert_duration_ms,
	// [67:52] alert_tag, [71:68] zero
	input  wire logic [71:0] s_tdata,
	// [1:0] op
	input  wire logic [1:0]  s_tuser,
	// Result beats.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] accepted, [1] dropped_oldest, [2] frame_taken, [3] showing,
	// [4] started_new, [8:5] current_type, [24:9] current_tag,
	// [28:25] queue_count, [31:29] zero
	output logic [31:0]      m_tdata,
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import rlaq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [7:0] DEPTH8 = 8'(QUEUE_DEPTH);

	// Input fields.
	logic [1:0]  op;
	logic [31:0] now_ms;
	alert_t      in_alert;

	assign op             = s_tuser;
	assign now_ms         = s_tdata[31:0];
	assign in_alert.atype = s_tdata[35:32];
	assign in_alert.dur   = s_tdata[51:36];
	assign in_alert.tag   = s_tdata[67:52];

	// Configuration registers and divider.
	logic [15:0] round_ms_q;
	logic [7:0]  max_per_type_q;
	logic [3:0]  max_queue_q;
	logic        cfg_fire;
	logic        div_start;
	fdiv_stat_t  stat;

	assign cfg_ready = !stat.busy;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign div_start = cfg_fire && (cfg_index == REG_MAX_FPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_ms_q     <= ROUND_MS_RST;
			max_per_type_q <= MAX_PER_TYPE_RST;
			max_queue_q    <= MAX_QUEUE_RST;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_ROUND_MS:     round_ms_q     <= cfg_data;
				REG_MAX_PER_TYPE: max_per_type_q <= cfg_data[7:0];
				REG_MAX_QUEUE:    max_queue_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	rlaq_fdiv u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.fps    (cfg_data[7:0]),
		.stat   (stat)
	);

	// Handshake: the output register frees as its beat leaves.
	logic res_valid_q;
	res_t res_q;
	res_t res_d;
	logic in_fire;

	assign s_tready = !stat.busy && (!res_valid_q || m_tready);
	assign in_fire  = s_tvalid && s_tready;

	// Control state.
	logic [CNT_W-1:0] count_q;
	logic [31:0]      round_start_q;
	logic [31:0]      last_frame_q;
	logic             show_q;
	logic [31:0]      show_until_q;
	alert_t           shown_q;

	// Queue cells; cell 0 is the oldest alert.
	alert_t           slot_data [QUEUE_DEPTH];
	logic [CNT_W-1:0] wr_pos;
	logic             q_load;
	logic             q_shift;

	// Per-type counter cells.
	tcell_ctl_t            tctl;
	logic [TYPE_COUNT-1:0] full_hit;

	// Next-state decode for one beat.
	logic             restart;
	logic             refuse;
	logic             drop;
	logic             gate;
	logic             still;
	logic             push_ok;
	logic             pop;
	logic             taken;
	logic [7:0]       cnt8;
	logic [7:0]       mq8;
	logic [7:0]       lim8;
	logic [CNT_W-1:0] count_d;
	logic             show_d;
	alert_t           shown_d;
	logic [31:0]      until_d;

	always_comb begin
		restart = (now_ms - round_start_q) > {16'd0, round_ms_q};
		refuse  = |full_hit;
		cnt8    = 8'(count_q);
		mq8     = {4'd0, max_queue_q};
		if (mq8 == 8'd0) begin
			lim8 = 8'd1;
		end else if (mq8 > DEPTH8) begin
			lim8 = DEPTH8;
		end else begin
			lim8 = mq8;
		end
		drop    = (cnt8 >= lim8) && (count_q != '0);
		gate    = (now_ms - last_frame_q) >= {{(32 - INT_W){1'b0}}, stat.interval};
		still   = show_q && (now_ms < show_until_q);
		push_ok = 1'b0;
		pop     = 1'b0;
		taken   = 1'b0;
		count_d = count_q;
		show_d  = show_q;
		shown_d = shown_q;
		until_d = show_until_q;
		case (op)
			OP_PUSH: begin
				if (!refuse) begin
					push_ok = 1'b1;
					count_d = count_q - CNT_W'(drop) + CNT_W'(1);
				end
			end
			OP_TICK: begin
				if (gate) begin
					taken = 1'b1;
					if (!still) begin
						if (count_q != '0) begin
							pop     = 1'b1;
							count_d = count_q - CNT_W'(1);
							show_d  = 1'b1;
							shown_d = slot_data[0];
							until_d = now_ms + {16'd0, slot_data[0].dur};
						end else begin
							show_d = 1'b0;
						end
					end
				end
			end
			OP_CLEAR: count_d = '0;
			default: ;
		endcase

		res_d.accepted = push_ok;
		res_d.dropped  = push_ok && drop;
		res_d.taken    = taken;
		res_d.showing  = show_d;
		res_d.started  = pop;
		res_d.cur_type = show_d ? shown_d.atype : 4'd0;
		res_d.cur_tag  = show_d ? shown_d.tag : 16'd0;
		res_d.qcount   = 4'(count_d);
	end

	// Queue write position and shift enable.
	assign wr_pos  = count_q - CNT_W'(drop);
	assign q_load  = in_fire && push_ok;
	assign q_shift = in_fire && ((push_ok && drop) || pop);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
		alert_t next_data;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_data = '0;
		end else begin : g_mid
			assign next_data = slot_data[i + 1];
		end
		rlaq_slot u_slot (
			.clk   (clk),
			.load  (q_load && (wr_pos == CNT_W'(i))),
			.shift (q_shift),
			.wdata (in_alert),
			.next  (next_data),
			.data  (slot_data[i])
		);
	end

	assign tctl.upd     = in_fire && (op == OP_PUSH);
	assign tctl.restart = restart;
	assign tctl.bump    = push_ok;

	for (genvar k = 0; k < TYPE_COUNT; k++) begin : g_type
		rlaq_tcell #(
			.MATCH (type_match(k, TYPE_COUNT))
		) u_tcell (
			.clk          (clk),
			.arst_n       (arst_n),
			.alert_type   (in_alert.atype),
			.max_per_type (max_per_type_q),
			.ctl          (tctl),
			.full_hit     (full_hit[k])
		);
	end

	// State update on an accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			round_start_q <= '0;
			last_frame_q  <= '0;
			show_q        <= 1'b0;
			show_until_q  <= '0;
			shown_q       <= '0;
		end else if (in_fire) begin
			count_q      <= count_d;
			show_q       <= show_d;
			shown_q      <= shown_d;
			show_until_q <= until_d;
			if ((op == OP_PUSH) && restart) begin
				round_start_q <= now_ms;
			end
			if (taken) begin
				last_frame_q <= now_ms;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_fire) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {3'd0, res_q.qcount, res_q.cur_tag, res_q.cur_type, res_q.started,
		res_q.showing, res_q.taken, res_q.dropped, res_q.accepted};

	// The fill never passes the queue depth.
	`RLAQ_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "queue fill beyond depth")
	// A started alert comes only from a taken tick and is then showing.
	`RLAQ_ASSERT_IMP(a_start_taken, res_valid_q && res_q.started, res_q.taken && res_q.showing, "start without taken tick")
	// Only an accepted push may evict the oldest alert.
	`RLAQ_ASSERT_IMP(a_drop_acc, res_valid_q && res_q.dropped, res_q.accepted, "drop on refused push")

endmodule

`default_nettype wire

// ===== sv/rlaq_slot.sv =====
// One queue cell of the alert queue: holds one pending alert.
// Depends on rlaq_pkg for the alert type.
`default_nettype none

module rlaq_slot (
	input  wire logic            clk,
	input  wire logic            load,
	input  wire logic            shift,
	input  wire rlaq_pkg::alert_t wdata,
	input  wire rlaq_pkg::alert_t next,
	output rlaq_pkg::alert_t      data
);
	import rlaq_pkg::*;

	alert_t data_q;

	// A new alert wins over the shift from the upper neighbor.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= wdata;
		end else if (shift) begin
			data_q <= next;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== sv/rlaq_tcell.sv =====
// Per-type use counter cell of the alert queue.
// Depends on rlaq_pkg for the control struct.
`default_nettype none

module rlaq_tcell #(
	parameter logic [15:0] MATCH = 16'h0001
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [3:0]          alert_type,
	input  wire logic [7:0]          max_per_type,
	input  wire rlaq_pkg::tcell_ctl_t ctl,
	output logic                     full_hit
);
	import rlaq_pkg::*;

	logic [7:0] cnt_q;
	logic [7:0] cnt_eff;
	logic       hit;

	// A round restart makes the count read as zero for this beat.
	assign hit      = MATCH[alert_type];
	assign cnt_eff  = ctl.restart ? 8'd0 : cnt_q;
	assign full_hit = hit && (cnt_eff >= max_per_type);

	// Clear on restart, count accepted pushes of this type.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.upd) begin
			if (ctl.bump && hit) begin
				cnt_q <= cnt_eff + 8'd1;
			end else begin
				cnt_q <= cnt_eff;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/rlaq_fdiv.sv =====
// Frame interval divider: 1000 / max(fps, 1), one quotient bit per cycle.
// Depends on rlaq_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rlaq_fdiv (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [7:0]         fps,
	output rlaq_pkg::fdiv_stat_t     stat
);
	import rlaq_pkg::*;

	logic             busy_q;
	logic [3:0]       step_q;
	logic [7:0]       div_q;
	logic [7:0]       rem_q;
	logic [INT_W-1:0] num_q;
	logic [INT_W-1:0] quo_q;
	logic [8:0]       rem_sh;
	logic             fits;

	// Restoring division step.
	assign rem_sh = {rem_q, num_q[INT_W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			div_q  <= 8'd1;
			rem_q  <= '0;
			num_q  <= '0;
			quo_q  <= FRAME_INT_RST;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= DIV_STEPS;
			div_q  <= (fps == 8'd0) ? 8'd1 : fps;
			rem_q  <= '0;
			num_q  <= MS_PER_SECOND;
		end else if (busy_q) begin
			rem_q  <= fits ? 8'(rem_sh - {1'b0, div_q}) : rem_sh[7:0];
			quo_q  <= {quo_q[INT_W-2:0], fits};
			num_q  <= {num_q[INT_W-2:0], 1'b0};
			step_q <= step_q - 4'd1;
			busy_q <= (step_q != 4'd1);
		end
	end

	assign stat.busy     = busy_q;
	assign stat.interval = quo_q;

	// 1000 divided by at most 255 never drops below three.
	`RLAQ_ASSERT_IMP(a_interval_min, $fell(busy_q), quo_q >= 10'd3, "frame interval too small")

endmodule

`default_nettype wire
